>>> hw/rtl/notch_lowpass_biquad_cascade_unit_assert.svh
// Assertion macros for the notch and low-pass biquad cascade unit.
`ifndef NOTCH_LOWPASS_BIQUAD_CASCADE_UNIT_ASSERT_SVH
`define NOTCH_LOWPASS_BIQUAD_CASCADE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define NLBC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nlbc: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define NLBC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nlbc: next-cycle check failed");
`else
`define NLBC_ASSERT_SAME(label, clk, rstn, ante, cons)
`define NLBC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/nlbc_pkg.sv
// Shared types, constants and coefficient ROM of the biquad cascade unit.
package nlbc_pkg;

    // Fixed field widths and number formats
    localparam int SAMPLE_WIDTH   = 24;
    localparam int CFG_WIDTH      = 16;
    localparam int STATE_WIDTH    = 48;
    localparam int STATE_FRAC     = 16;
    localparam int WORDS_PER_CH   = 6;
    // widest multiplicand is w + 2*w1 + w2
    localparam int OPA_WIDTH      = 50;
    localparam int HALF_WIDTH     = 25;
    localparam int COEF_SETS      = 3;
    localparam int COEFS_PER_SET  = 9;

    // Defaults of the top-level parameters
    localparam int CHANNELS_DEF       = 2;
    localparam int COEF_FRAC_BITS_DEF = 30;

    // Sample interval thresholds and reset value
    localparam logic [CFG_WIDTH-1:0] INTERVAL_RESET = 16'd2000;
    localparam logic [CFG_WIDTH-1:0] INTERVAL_SLOW  = 16'd3500;
    localparam logic [CFG_WIDTH-1:0] INTERVAL_MID   = 16'd1500;

    // Item commands
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Coefficient set codes
    typedef logic [1:0] coef_set_t;
    localparam coef_set_t SET_SLOW = 2'd0;
    localparam coef_set_t SET_MID  = 2'd1;
    localparam coef_set_t SET_FAST = 2'd2;

    // Coefficient index within a set
    typedef logic [3:0] coef_idx_t;
    localparam coef_idx_t COEF_NOTCH_B0 = 4'd0;
    localparam coef_idx_t COEF_NOTCH_A1 = 4'd1;
    localparam coef_idx_t COEF_NOTCH_A2 = 4'd2;
    localparam coef_idx_t COEF_LP1_A1   = 4'd3;
    localparam coef_idx_t COEF_LP1_A2   = 4'd4;
    localparam coef_idx_t COEF_LP1_GAIN = 4'd5;
    localparam coef_idx_t COEF_LP2_A1   = 4'd6;
    localparam coef_idx_t COEF_LP2_A2   = 4'd7;
    localparam coef_idx_t COEF_LP2_GAIN = 4'd8;

    // Section codes
    typedef logic [1:0] sec_t;
    localparam sec_t SEC_NOTCH = 2'd0;
    localparam sec_t SEC_LP1   = 2'd1;
    localparam sec_t SEC_LP2   = 2'd2;

    // Coefficients, signed Q2.30: notch b0 a1 a2, lp1 a1 a2 gain, lp2 a1 a2 gain
    localparam logic signed [31:0] COEF_Q30 [COEF_SETS][COEFS_PER_SET] = '{
        '{ 32'sd953310679,  -32'sd589178401,  32'sd832879533,
           32'sd1125925222,  32'sd317978288,  32'sd464765546,
           32'sd1418319997,  32'sd679398106,  32'sd1073741824 },
        '{ 32'sd996642447,  -32'sd1612601354, 32'sd919543070,
          -32'sd486533381,   32'sd500713269,  32'sd271980428,
          -32'sd353234944,   32'sd69350466,   32'sd197464337 },
        '{ 32'sd1041026256, -32'sd1980149609, 32'sd1008310688,
          -32'sd1125925222,  32'sd317978288,  32'sd5180099,
          -32'sd1418319997,  32'sd679398106,  32'sd1073741824 }
    };

    // Multiplier operand source
    typedef enum logic [1:0] {
        OPA_D1  = 2'd0,
        OPA_D2  = 2'd1,
        OPA_W   = 2'd2,
        OPA_SUM = 2'd3
    } opa_sel_t;

    // Delay word within a section: w[n-1] or w[n-2]
    typedef enum logic {
        SLOT_W1 = 1'b0,
        SLOT_W2 = 1'b1
    } slot_t;

    // Payload of one input and one result transaction
    typedef struct packed {
        logic                           command;
        logic                           channel;
        logic signed [SAMPLE_WIDTH-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic                           out_channel;
        logic signed [SAMPLE_WIDTH-1:0] filtered;
        logic                           saturated;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      item_load;
        logic      clr_chan;
        logic      rd_en;
        logic      wr_en;
        slot_t     slot;
        sec_t      sec;
        logic      cap_d1;
        logic      cap_d2;
        logic      acc_init;
        logic      phase_out;
        logic      mul_en;
        logic      mul_hi;
        logic      mul_sub;
        opa_sel_t  opa_sel;
        coef_idx_t coef_idx;
        logic      rnd_w;
        logic      rnd_y;
        logic      out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic item_clear;
        logic item_chan_ok;
        logic out_free;
    } dp_sts_t;

endpackage

>>> hw/rtl/nlbc_ctrl.sv
// Sequencer of the biquad cascade: walks sections, product terms and write-back.
module nlbc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nlbc_pkg::dp_sts_t sts,
    output nlbc_pkg::dp_cmd_t cmd
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_CLEAR  = 13'b0000000000010,
        ST_RD1    = 13'b0000000000100,
        ST_RD2    = 13'b0000000001000,
        ST_CAP    = 13'b0000000010000,
        ST_PREP   = 13'b0000000100000,
        ST_MUL_LO = 13'b0000001000000,
        ST_MUL_HI = 13'b0000010000000,
        ST_DRAIN  = 13'b0000100000000,
        ST_ROUND  = 13'b0001000000000,
        ST_WR1    = 13'b0010000000000,
        ST_WR2    = 13'b0100000000000,
        ST_FIN    = 13'b1000000000000
    } state_t;

    // One product term of a sum of products
    typedef struct packed {
        nlbc_pkg::opa_sel_t  opa_sel;
        nlbc_pkg::coef_idx_t coef_idx;
        logic                sub;
        logic                last;
    } term_t;

    state_t         state_reg, state_next;
    nlbc_pkg::sec_t sec_reg, sec_next;
    logic           phase_reg, phase_next;
    logic [1:0]     term_reg, term_next;
    term_t          term;

    // Node: in - a1*w1 - a2*w2. Output: notch b0*w + a1*w1 + b0*w2,
    // low-pass gain*(w + 2*w1 + w2).
    function automatic term_t term_lookup(nlbc_pkg::sec_t sec, logic phase_out,
                                          logic [1:0] idx);
        term_t t;
        t.opa_sel  = nlbc_pkg::OPA_D1;
        t.coef_idx = nlbc_pkg::COEF_NOTCH_B0;
        t.sub      = 1'b0;
        t.last     = 1'b1;
        if (!phase_out) begin
            t.sub     = 1'b1;
            t.last    = idx[0];
            t.opa_sel = idx[0] ? nlbc_pkg::OPA_D2 : nlbc_pkg::OPA_D1;
            case (sec)
                nlbc_pkg::SEC_NOTCH: begin
                    t.coef_idx = idx[0] ? nlbc_pkg::COEF_NOTCH_A2 : nlbc_pkg::COEF_NOTCH_A1;
                end
                nlbc_pkg::SEC_LP1: begin
                    t.coef_idx = idx[0] ? nlbc_pkg::COEF_LP1_A2 : nlbc_pkg::COEF_LP1_A1;
                end
                default: begin
                    t.coef_idx = idx[0] ? nlbc_pkg::COEF_LP2_A2 : nlbc_pkg::COEF_LP2_A1;
                end
            endcase
        end else if (sec == nlbc_pkg::SEC_NOTCH) begin
            case (idx)
                2'd0: begin
                    t.opa_sel  = nlbc_pkg::OPA_W;
                    t.coef_idx = nlbc_pkg::COEF_NOTCH_B0;
                    t.last     = 1'b0;
                end
                2'd1: begin
                    t.opa_sel  = nlbc_pkg::OPA_D1;
                    t.coef_idx = nlbc_pkg::COEF_NOTCH_A1;
                    t.last     = 1'b0;
                end
                default: begin
                    t.opa_sel  = nlbc_pkg::OPA_D2;
                    t.coef_idx = nlbc_pkg::COEF_NOTCH_B0;
                end
            endcase
        end else begin
            t.opa_sel  = nlbc_pkg::OPA_SUM;
            t.coef_idx = (sec == nlbc_pkg::SEC_LP1) ? nlbc_pkg::COEF_LP1_GAIN
                                                    : nlbc_pkg::COEF_LP2_GAIN;
        end
        return t;
    endfunction

    assign term = term_lookup(sec_reg, phase_reg, term_reg);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        sec_next   = sec_reg;
        phase_next = phase_reg;
        term_next  = term_reg;
        cmd        = '0;
        cmd.sec       = sec_reg;
        cmd.phase_out = phase_reg;
        cmd.opa_sel   = term.opa_sel;
        cmd.coef_idx  = term.coef_idx;
        cmd.mul_sub   = term.sub;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.item_load = s_valid;
                if (s_valid && sts.item_chan_ok) begin
                    if (sts.item_clear) begin
                        state_next = ST_CLEAR;
                    end else begin
                        sec_next   = nlbc_pkg::SEC_NOTCH;
                        state_next = ST_RD1;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.clr_chan = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_RD1: begin
                cmd.rd_en  = 1'b1;
                cmd.slot   = nlbc_pkg::SLOT_W1;
                state_next = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd_en  = 1'b1;
                cmd.slot   = nlbc_pkg::SLOT_W2;
                cmd.cap_d1 = 1'b1;
                state_next = ST_CAP;
            end
            ST_CAP: begin
                cmd.cap_d2 = 1'b1;
                phase_next = 1'b0;
                term_next  = 2'd0;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.acc_init = 1'b1;
                state_next   = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.mul_en = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_en = 1'b1;
                cmd.mul_hi = 1'b1;
                if (term.last) begin
                    state_next = ST_DRAIN;
                end else begin
                    term_next  = term_reg + 2'd1;
                    state_next = ST_MUL_LO;
                end
            end
            // last partial product lands in the accumulator
            ST_DRAIN: begin
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                if (!phase_reg) begin
                    cmd.rnd_w  = 1'b1;
                    phase_next = 1'b1;
                    term_next  = 2'd0;
                    state_next = ST_PREP;
                end else begin
                    cmd.rnd_y  = 1'b1;
                    state_next = ST_WR1;
                end
            end
            ST_WR1: begin
                cmd.wr_en  = 1'b1;
                cmd.slot   = nlbc_pkg::SLOT_W2;
                state_next = ST_WR2;
            end
            ST_WR2: begin
                cmd.wr_en = 1'b1;
                cmd.slot  = nlbc_pkg::SLOT_W1;
                if (sec_reg == nlbc_pkg::SEC_LP2) begin
                    state_next = ST_FIN;
                end else begin
                    sec_next   = sec_reg + 2'd1;
                    state_next = ST_RD1;
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sec_reg   <= nlbc_pkg::SEC_NOTCH;
            phase_reg <= 1'b0;
            term_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            sec_reg   <= sec_next;
            phase_reg <= phase_next;
            term_reg  <= term_next;
        end
    end

endmodule

>>> hw/rtl/nlbc_datapath.sv
// Datapath of the biquad cascade: delay memory, shared MAC, rounding and output register.
module nlbc_datapath #(
    parameter int CHANNELS       = nlbc_pkg::CHANNELS_DEF,
    parameter int COEF_FRAC_BITS = nlbc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [nlbc_pkg::CFG_WIDTH-1:0]    cfg_wr_data,
    input  nlbc_pkg::in_item_t                s_data,
    input  logic                              m_ready,
    output logic                              m_valid,
    output nlbc_pkg::out_item_t               m_data,
    input  nlbc_pkg::dp_cmd_t                 cmd,
    output nlbc_pkg::dp_sts_t                 sts
);

    localparam int SW       = nlbc_pkg::SAMPLE_WIDTH;
    localparam int STW      = nlbc_pkg::STATE_WIDTH;
    localparam int SFR      = nlbc_pkg::STATE_FRAC;
    localparam int OPW      = nlbc_pkg::OPA_WIDTH;
    localparam int HW       = nlbc_pkg::HALF_WIDTH;
    localparam int DEPTH    = CHANNELS * nlbc_pkg::WORDS_PER_CH;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = COEF_FRAC_BITS + 2;
    localparam int CS       = 30 - COEF_FRAC_BITS;
    localparam int HALF_SH  = (CS > 0) ? CS - 1 : 0;
    localparam int MW       = HW + 1;
    localparam int PW       = MW + CW;
    localparam int ACC_W    = OPW + CW;
    localparam int RQ_W     = ACC_W - COEF_FRAC_BITS;
    localparam int OQ_W     = STW + 1 - SFR;

    localparam logic [32:0]      COEF_HALF = (CS > 0) ? (33'd1 << HALF_SH) : 33'd0;
    localparam logic [ACC_W-1:0] RND_HALF  =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic [STW:0]     OUT_HALF  = {{STW{1'b0}}, 1'b1} << (SFR - 1);
    localparam logic [STW-1:0]   STATE_MAX = {1'b0, {(STW-1){1'b1}}};
    localparam logic [STW-1:0]   STATE_MIN = {1'b1, {(STW-1){1'b0}}};
    localparam logic [SW-1:0]    SMP_MAX   = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0]    SMP_MIN   = {1'b1, {(SW-1){1'b0}}};

    // Configuration and per-transaction registers
    logic [nlbc_pkg::CFG_WIDTH-1:0] cfg_reg;
    logic                           chan_reg;
    nlbc_pkg::coef_set_t            set_reg, set_sel;
    logic signed [STW-1:0]          y_reg, d1_reg, d2_reg, w_reg;
    logic signed [OPW-1:0]          sum_reg, sum_full;
    logic                           sat_reg;

    // Delay memory
    logic [STW-1:0]   mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [STW-1:0]   rd_q_reg;
    logic             rd_vld_reg;
    logic [STW-1:0]   rd_word, wr_word;
    logic [AW-1:0]    base_addr, word_addr;

    // MAC
    logic signed [OPW-1:0]   opa;
    logic signed [MW-1:0]    mul_in;
    logic signed [31:0]      coef_raw;
    logic signed [32:0]      coef_sum, coef_shr;
    logic signed [CW-1:0]    coef_val;
    logic signed [PW-1:0]    prod_full, prod_reg;
    logic                    prod_vld_reg, prod_hi_reg, prod_sub_reg;
    logic signed [ACC_W-1:0] addend_ext, addend, acc_reg, acc_next;

    // Rounding to the state format
    logic [ACC_W-1:0] rnd_sum;
    logic [RQ_W-1:0]  rnd_q;
    logic             rnd_fit;
    logic [STW-1:0]   rnd_val;

    // Final rounding to the sample format
    logic signed [STW:0] out_t;
    logic [OQ_W-1:0]     out_q;
    logic                out_fit;
    logic [SW-1:0]       filtered_val;

    logic                m_valid_reg;
    nlbc_pkg::out_item_t m_data_reg;

    // Status to the controller
    assign sts.item_clear   = (s_data.command == nlbc_pkg::CMD_CLEAR);
    assign sts.item_chan_ok = (int'(s_data.channel) < CHANNELS);
    assign sts.out_free     = !m_valid_reg || m_ready;

    // Coefficient set from the sample interval
    always_comb begin
        if (cfg_reg >= nlbc_pkg::INTERVAL_SLOW) begin
            set_sel = nlbc_pkg::SET_SLOW;
        end else if (cfg_reg >= nlbc_pkg::INTERVAL_MID) begin
            set_sel = nlbc_pkg::SET_MID;
        end else begin
            set_sel = nlbc_pkg::SET_FAST;
        end
    end

    // Memory addressing: channel base + 2*section + slot
    assign base_addr = AW'(chan_reg) * AW'(nlbc_pkg::WORDS_PER_CH);
    assign word_addr = base_addr + AW'({cmd.sec, 1'b0}) + AW'(cmd.slot);
    assign rd_word   = rd_vld_reg ? rd_q_reg : '0;
    assign wr_word   = (cmd.slot == nlbc_pkg::SLOT_W2) ? d1_reg : w_reg;

    // Multiplicand select
    always_comb begin
        unique case (cmd.opa_sel)
            nlbc_pkg::OPA_D1:  opa = {{(OPW-STW){d1_reg[STW-1]}}, d1_reg};
            nlbc_pkg::OPA_D2:  opa = {{(OPW-STW){d2_reg[STW-1]}}, d2_reg};
            nlbc_pkg::OPA_W:   opa = {{(OPW-STW){w_reg[STW-1]}}, w_reg};
            nlbc_pkg::OPA_SUM: opa = sum_reg;
            default:           opa = '0;
        endcase
    end

    // Half of the multiplicand: low half unsigned, high half signed
    assign mul_in = cmd.mul_hi ? {opa[OPW-1], opa[OPW-1:HW]} : {1'b0, opa[HW-1:0]};

    // Coefficient taken to COEF_FRAC_BITS by round half up
    assign coef_raw  = nlbc_pkg::COEF_Q30[set_reg][cmd.coef_idx];
    assign coef_sum  = {coef_raw[31], coef_raw} + COEF_HALF;
    assign coef_shr  = coef_sum >>> CS;
    assign coef_val  = coef_shr[CW-1:0];
    assign prod_full = mul_in * coef_val;

    // Accumulator: init, or add/subtract the registered partial product
    assign addend_ext = ACC_W'(prod_reg);
    assign addend     = prod_hi_reg ? (addend_ext <<< HW) : addend_ext;

    always_comb begin
        acc_next = acc_reg;
        if (cmd.acc_init) begin
            acc_next = cmd.phase_out ? '0 : (ACC_W'(y_reg) <<< COEF_FRAC_BITS);
        end else if (prod_vld_reg) begin
            acc_next = prod_sub_reg ? (acc_reg - addend) : (acc_reg + addend);
        end
    end

    // Round half up to 16 fraction bits and clip to 48 bits
    assign rnd_sum = acc_reg + RND_HALF;
    assign rnd_q   = rnd_sum[ACC_W-1:COEF_FRAC_BITS];
    assign rnd_fit = (&rnd_q[RQ_W-1:STW-1]) | ~(|rnd_q[RQ_W-1:STW-1]);
    assign rnd_val = rnd_fit ? rnd_q[STW-1:0] : (rnd_q[RQ_W-1] ? STATE_MIN : STATE_MAX);

    // Low-pass numerator 1,2,1
    assign sum_full = OPW'(w_reg) + (OPW'(d1_reg) <<< 1) + OPW'(d2_reg);

    // Output: round half up to an integer, clip to the sample width
    assign out_t        = (STW+1)'(y_reg) + OUT_HALF;
    assign out_q        = out_t[STW:SFR];
    assign out_fit      = (&out_q[OQ_W-1:SW-1]) | ~(|out_q[OQ_W-1:SW-1]);
    assign filtered_val = out_fit ? out_q[SW-1:0] : (out_q[OQ_W-1] ? SMP_MIN : SMP_MAX);

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= nlbc_pkg::INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            chan_reg <= s_data.channel;
            set_reg  <= set_sel;
            y_reg    <= STW'(s_data.sample) <<< SFR;
            sat_reg  <= 1'b0;
        end else begin
            if (cmd.rnd_y) begin
                y_reg <= rnd_val;
            end
            if (cmd.rnd_w || cmd.rnd_y) begin
                sat_reg <= sat_reg | !rnd_fit;
            end
        end
        if (cmd.cap_d1) begin
            d1_reg <= rd_word;
        end
        if (cmd.cap_d2) begin
            d2_reg <= rd_word;
        end
        if (cmd.rnd_w) begin
            w_reg <= rnd_val;
        end
        if (cmd.acc_init) begin
            sum_reg <= sum_full;
        end
        if (cmd.mul_en) begin
            prod_reg     <= prod_full;
            prod_hi_reg  <= cmd.mul_hi;
            prod_sub_reg <= cmd.mul_sub;
        end
        acc_reg <= acc_next;
    end

    // Partial product pending for the accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= cmd.mul_en;
        end
    end

    // Delay memory, one port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[word_addr] <= wr_word;
        end
        if (cmd.rd_en) begin
            rd_q_reg   <= mem[word_addr];
            rd_vld_reg <= vld_reg[word_addr];
        end
    end

    // Word valid bits: unwritten or cleared words read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (cmd.clr_chan) begin
                for (int k = 0; k < nlbc_pkg::WORDS_PER_CH; k++) begin
                    vld_reg[base_addr + AW'(k)] <= 1'b0;
                end
            end
            if (cmd.wr_en) begin
                vld_reg[word_addr] <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.out_channel <= chan_reg;
            m_data_reg.filtered    <= filtered_val;
            m_data_reg.saturated   <= sat_reg | !out_fit;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hw/rtl/notch_lowpass_biquad_cascade_unit.sv
// Filter transaction: one result per input; an input is taken only while idle.
// Processing time is set by the single shared 26x32 multiplier (two passes per 50-bit
// multiplicand) and the one-port delay memory (two reads and two writes per section).
// Clear transaction: no result. Output register lets the next input be taken
// while a result waits. Synchronous active-low reset clears all delay-word valid bits
// at once, so every delay word reads as zero, and sets the sample interval to 2000 us.
`include "notch_lowpass_biquad_cascade_unit_assert.svh"
module notch_lowpass_biquad_cascade_unit #(
    parameter int CHANNELS       = nlbc_pkg::CHANNELS_DEF,
    parameter int COEF_FRAC_BITS = nlbc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [nlbc_pkg::CFG_WIDTH-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  nlbc_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output nlbc_pkg::out_item_t            m_data
);

    nlbc_pkg::dp_cmd_t ctrl_cmd;
    nlbc_pkg::dp_sts_t dp_sts;

    // Sequencer
    nlbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (dp_sts),
        .cmd     (ctrl_cmd)
    );

    // Datapath
    nlbc_datapath #(
        .CHANNELS       (CHANNELS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .cmd         (ctrl_cmd),
        .sts         (dp_sts)
    );

    // A result is loaded only into a free output register
    `NLBC_ASSERT_SAME(a_out_load_free, aclk, aresetn, ctrl_cmd.out_load, !m_valid || m_ready)
    // An accepted transaction for a present channel starts work
    `NLBC_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready && dp_sts.item_chan_ok, !s_ready)
    // Delay memory is written only while a transaction is in flight
    `NLBC_ASSERT_SAME(a_wr_busy, aclk, aresetn, ctrl_cmd.wr_en, !s_ready)

endmodule

>>> dv/tb_top.sv
// Testbench for the two-channel notch and low-pass biquad cascade unit.
`timescale 1ns / 1ps
module tb_top;
    import nlbc_pkg::*;

    localparam int COEF_FRAC       = 30;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int SETTLE_CYCLES   = 80;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int WATCHDOG_LIMIT  = 20000;

    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = 24'sh800000;

    localparam logic signed [127:0] WORD_MAX  = (128'sd1 <<< (STATE_WIDTH - 1)) - 128'sd1;
    localparam logic signed [127:0] WORD_MIN  = -(128'sd1 <<< (STATE_WIDTH - 1));
    localparam logic signed [127:0] OUT_MAX   = (128'sd1 <<< (SAMPLE_WIDTH - 1)) - 128'sd1;
    localparam logic signed [127:0] OUT_MIN   = -(128'sd1 <<< (SAMPLE_WIDTH - 1));
    localparam logic signed [127:0] COEF_HALF = 128'sd1 <<< (COEF_FRAC - 1);
    localparam logic signed [127:0] OUT_HALF  = 128'sd1 <<< (STATE_FRAC - 1);

    // Q2.30 coefficients per set: notch b0 a1 a2, lp1 a1 a2 gain, lp2 a1 a2 gain
    localparam logic signed [31:0] BIQUAD_COEFS [3][9] = '{
        '{ 32'sd953310679,  -32'sd589178401,  32'sd832879533,
           32'sd1125925222,  32'sd317978288,  32'sd464765546,
           32'sd1418319997,  32'sd679398106,  32'sd1073741824 },
        '{ 32'sd996642447,  -32'sd1612601354, 32'sd919543070,
          -32'sd486533381,   32'sd500713269,  32'sd271980428,
          -32'sd353234944,   32'sd69350466,   32'sd197464337 },
        '{ 32'sd1041026256, -32'sd1980149609, 32'sd1008310688,
          -32'sd1125925222,  32'sd317978288,  32'sd5180099,
          -32'sd1418319997,  32'sd679398106,  32'sd1073741824 }
    };

    // sample interval settings on the set boundaries and at the ends of the range
    localparam logic [CFG_WIDTH-1:0] BOUNDARY_INTERVALS [6] = '{
        16'd0, 16'd3500, 16'd1499, 16'd65535, 16'd1500, 16'd3499
    };

    typedef enum logic [1:0] {
        RUN_NOISE = 2'd0,
        RUN_STEP  = 2'd1,
        RUN_QUIET = 2'd2,
        RUN_SWING = 2'd3
    } run_kind_t;

    typedef struct {
        logic [CFG_WIDTH-1:0]           interval;
        logic                           cmd;
        logic                           ch;
        logic signed [SAMPLE_WIDTH-1:0] smp;
        bit                             known;
        out_item_t                      result;
    } stim_row_t;

    // Directed rows; typed results only where the answer is plainly zero
    stim_row_t directed_rows [25] = '{
        '{16'd2000,  CMD_FILTER, 1'b0, 24'sd0,      1'b1, '{1'b0, 24'sd0, 1'b0}},
        '{16'd2000,  CMD_FILTER, 1'b1, 24'sd0,      1'b1, '{1'b1, 24'sd0, 1'b0}},
        '{16'd2000,  CMD_FILTER, 1'b0, SMP_MAX,     1'b0, '0},
        '{16'd2000,  CMD_FILTER, 1'b1, SMP_MIN,     1'b0, '0},
        '{16'd2000,  CMD_FILTER, 1'b0, SMP_MIN,     1'b0, '0},
        '{16'd2000,  CMD_FILTER, 1'b1, SMP_MAX,     1'b0, '0},
        '{16'd2000,  CMD_FILTER, 1'b0, -24'sd1,     1'b0, '0},
        '{16'd2000,  CMD_FILTER, 1'b1, 24'sd1,      1'b0, '0},
        '{16'd2000,  CMD_CLEAR,  1'b0, SMP_MAX,     1'b0, '0},
        '{16'd2000,  CMD_FILTER, 1'b0, 24'sd0,      1'b1, '{1'b0, 24'sd0, 1'b0}},
        '{16'd2000,  CMD_CLEAR,  1'b1, SMP_MIN,     1'b0, '0},
        '{16'd2000,  CMD_FILTER, 1'b1, 24'sd0,      1'b1, '{1'b1, 24'sd0, 1'b0}},
        '{16'd3500,  CMD_FILTER, 1'b0, SMP_MAX,     1'b0, '0},
        '{16'd3500,  CMD_FILTER, 1'b0, SMP_MAX,     1'b0, '0},
        '{16'd3499,  CMD_FILTER, 1'b1, SMP_MIN,     1'b0, '0},
        '{16'd1500,  CMD_FILTER, 1'b0, SMP_MIN,     1'b0, '0},
        '{16'd1499,  CMD_FILTER, 1'b1, SMP_MAX,     1'b0, '0},
        '{16'd0,     CMD_FILTER, 1'b0, SMP_MAX,     1'b0, '0},
        '{16'd0,     CMD_FILTER, 1'b0, SMP_MIN,     1'b0, '0},
        '{16'd65535, CMD_FILTER, 1'b1, 24'sh555555, 1'b0, '0},
        '{16'd65535, CMD_CLEAR,  1'b0, 24'sh2AAAAA, 1'b0, '0},
        '{16'd65535, CMD_FILTER, 1'b0, 24'sd0,      1'b1, '{1'b0, 24'sd0, 1'b0}},
        '{16'd65535, CMD_FILTER, 1'b0, 24'shAAAAAA, 1'b0, '0},
        '{16'd65535, CMD_CLEAR,  1'b1, 24'sd0,      1'b0, '0},
        '{16'd65535, CMD_FILTER, 1'b1, 24'sd0,      1'b1, '{1'b1, 24'sd0, 1'b0}}
    };

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_WIDTH-1:0] cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    in_item_t             s_data      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    out_item_t            m_data;

    // Predictor state: delay words per channel and the current interval
    logic signed [STATE_WIDTH-1:0] delay_taps [2][WORDS_PER_CH];
    logic [CFG_WIDTH-1:0]          interval_us = INTERVAL_RESET;
    bit                            clip_seen;
    out_item_t                     pending_outputs [$];
    int                            mismatches   = 0;
    int                            results_seen = 0;
    int                            idle_cycles  = 0;

    notch_lowpass_biquad_cascade_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // Clock and reset
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        foreach (delay_taps[c, k]) delay_taps[c][k] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Round half up out of COEF_FRAC bits, clip to the 48-bit state range
    function automatic logic signed [STATE_WIDTH-1:0] round_q30(
        input logic signed [127:0] acc
    );
        logic signed [127:0] v;
        v = (acc + COEF_HALF) >>> COEF_FRAC;
        if (v > WORD_MAX) begin
            clip_seen = 1'b1;
            v = WORD_MAX;
        end else if (v < WORD_MIN) begin
            clip_seen = 1'b1;
            v = WORD_MIN;
        end
        return v[STATE_WIDTH-1:0];
    endfunction

    // Section node: w = x - a1*w1 - a2*w2
    function automatic logic signed [127:0] biquad_node(
        input logic signed [127:0] x, a1, a2, d1, d2
    );
        return 128'(round_q30((x <<< COEF_FRAC) - a1 * d1 - a2 * d2));
    endfunction

    function automatic int pick_gap(input bit gapless);
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 50) return 0;
        if (r < 88) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    function automatic logic signed [31:0] coef_of(input coef_set_t cs, input coef_idx_t k);
        return BIQUAD_COEFS[cs][k];
    endfunction

    // Offer one transaction, then update the cascade model and queue its result
    task automatic offer_item(input in_item_t item, input int gap, input bit known,
                              input out_item_t typed);
        logic signed [127:0] y, w, d1, d2, b0, a1, a2, g, t;
        coef_set_t           cs;
        out_item_t           calc;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);

        if (item.command == CMD_CLEAR) begin
            for (int k = 0; k < WORDS_PER_CH; k++) delay_taps[item.channel][k] = '0;
        end else begin
            cs = interval_us >= INTERVAL_SLOW ? SET_SLOW :
                 (interval_us >= INTERVAL_MID ? SET_MID : SET_FAST);
            clip_seen = 1'b0;
            y = 128'(item.sample);
            y = y <<< STATE_FRAC;
            for (int s = 0; s < 3; s++) begin
                d1 = 128'(delay_taps[item.channel][2 * s + SLOT_W1]);
                d2 = 128'(delay_taps[item.channel][2 * s + SLOT_W2]);
                if (s == SEC_NOTCH) begin
                    // notch: b1 equals a1 and b2 equals b0
                    b0 = 128'(coef_of(cs, COEF_NOTCH_B0));
                    a1 = 128'(coef_of(cs, COEF_NOTCH_A1));
                    a2 = 128'(coef_of(cs, COEF_NOTCH_A2));
                    w  = biquad_node(y, a1, a2, d1, d2);
                    y  = 128'(round_q30(w * b0 + d1 * a1 + d2 * b0));
                end else begin
                    // low-pass: numerator 1,2,1 then gain
                    a1 = 128'(coef_of(cs, s == SEC_LP1 ? COEF_LP1_A1 : COEF_LP2_A1));
                    a2 = 128'(coef_of(cs, s == SEC_LP1 ? COEF_LP1_A2 : COEF_LP2_A2));
                    g  = 128'(coef_of(cs, s == SEC_LP1 ? COEF_LP1_GAIN : COEF_LP2_GAIN));
                    w  = biquad_node(y, a1, a2, d1, d2);
                    y  = 128'(round_q30((w + 2 * d1 + d2) * g));
                end
                delay_taps[item.channel][2 * s + SLOT_W2] = d1[STATE_WIDTH-1:0];
                delay_taps[item.channel][2 * s + SLOT_W1] = w[STATE_WIDTH-1:0];
            end
            // round to integer, saturate to sample width
            t = (y + OUT_HALF) >>> STATE_FRAC;
            if (t > OUT_MAX) begin
                t = OUT_MAX;
                clip_seen = 1'b1;
            end else if (t < OUT_MIN) begin
                t = OUT_MIN;
                clip_seen = 1'b1;
            end
            calc.out_channel = item.channel;
            calc.filtered    = t[SAMPLE_WIDTH-1:0];
            calc.saturated   = clip_seen;
            pending_outputs.push_back(known ? typed : calc);
        end
    endtask

    // Write the interval only once the unit has gone quiet
    task automatic set_interval(input logic [CFG_WIDTH-1:0] v);
        s_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        interval_us = v;
    endtask

    task automatic flag(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at result %0d: expected %0d, got %0d",
                     what, results_seen, want, got);
    endtask

    // Stimulus: directed rows, then random phases over several intervals
    initial begin : stimulus
        in_item_t  item;
        stim_row_t row;
        run_kind_t kind;
        int        run_left;
        logic signed [SAMPLE_WIDTH-1:0] held;
        bit        gapless;
        run_left = 0;
        held     = '0;
        kind     = RUN_NOISE;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.interval != interval_us) set_interval(row.interval);
            item.command = row.cmd;
            item.channel = row.ch;
            item.sample  = row.smp;
            offer_item(item, pick_gap(1'b0), row.known, row.result);
        end

        for (int p = 0; p < PHASES; p++) begin
            set_interval(p < 6 ? BOUNDARY_INTERVALS[p] : CFG_WIDTH'($urandom_range(0, 65535)));
            gapless = p[0];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // runs of one signal shape: noise, held steps, near zero, full swing
                if (run_left == 0) begin
                    kind     = run_kind_t'($urandom_range(0, 3));
                    run_left = $urandom_range(1, 24);
                    held     = $urandom_range(0, 1) ? SAMPLE_WIDTH'($urandom) :
                               ($urandom_range(0, 1) ? SMP_MAX : SMP_MIN);
                end
                run_left--;
                case (kind)
                    RUN_NOISE: item.sample = SAMPLE_WIDTH'($urandom);
                    RUN_STEP:  item.sample = held;
                    RUN_QUIET: item.sample = SAMPLE_WIDTH'(int'($urandom_range(0, 64)) - 32);
                    default:   item.sample = run_left[0] ? SMP_MAX : SMP_MIN;
                endcase
                item.command = $urandom_range(0, 99) < 4 ? CMD_CLEAR : CMD_FILTER;
                item.channel = 1'($urandom_range(0, 1));
                offer_item(item, pick_gap(gapless), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off that backs the unit up
    initial begin : receiver
        bit long_hold_done;
        int r;
        long_hold_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            r = $urandom_range(0, 99);
            if (!long_hold_done && results_seen >= 30) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                long_hold_done = 1'b1;
            end else if (r < 45) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 300)) @(posedge aclk);
            end else if (r < 85) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(20, 150)) @(posedge aclk);
            end
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                flag("unexpected result", 0, int'(m_data.filtered));
            end else begin
                want = pending_outputs.pop_front();
                if (m_data.out_channel !== want.out_channel)
                    flag("out_channel", int'(want.out_channel), int'(m_data.out_channel));
                if (m_data.filtered !== want.filtered)
                    flag("filtered", int'(want.filtered), int'(m_data.filtered));
                if (m_data.saturated !== want.saturated)
                    flag("saturated", int'(want.saturated), int'(m_data.saturated));
            end
            results_seen++;
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d quiet cycles", idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
